/* hdl/hmtq_pkg.sv */
// ----------------------------------------------------------------------------
// hmtq_pkg: shared types for the heightmap triangle height query block
// Holds the payload structs, the configuration register map and its snapshot.
// ----------------------------------------------------------------------------
package hmtq_pkg;

  // Register map of the configuration port
  typedef enum logic [2:0] {
    CFG_GRID_POINTS   = 3'd0,
    CFG_ORIGIN_X      = 3'd1,
    CFG_ORIGIN_Z      = 3'd2,
    CFG_INV_CELL_SIZE = 3'd3,
    CFG_HEIGHT_SCALE  = 3'd4
  } cfg_idx_e;

  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  typedef struct packed {
    logic               action;
    logic [7:0]         grid_col;
    logic [7:0]         grid_row;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic signed [31:0] query_x;
    logic signed [31:0] query_z;
  } in_item_t;

  typedef struct packed {
    logic [23:0] height;
    logic        inside_res;
  } out_item_t;

  // Current register values handed to the datapath
  typedef struct packed {
    logic [8:0]         grid_points;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_z;
    logic [31:0]        inv_cell_size;
    logic [23:0]        height_scale;
  } cfg_t;

endpackage

/* hdl/hmtq_cfg.sv */
// ----------------------------------------------------------------------------
// hmtq_cfg: configuration register file
// Takes one register write per beat and presents all registers as a struct.
// ----------------------------------------------------------------------------
module hmtq_cfg import hmtq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the write beat
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_POINTS:   cfg_d.grid_points   = cfg_data_i[8:0];
        CFG_ORIGIN_X:      cfg_d.origin_x      = cfg_data_i;
        CFG_ORIGIN_Z:      cfg_d.origin_z      = cfg_data_i;
        CFG_INV_CELL_SIZE: cfg_d.inv_cell_size = cfg_data_i;
        CFG_HEIGHT_SCALE:  cfg_d.height_scale  = cfg_data_i[23:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_points   <= 9'd256;
      cfg_q.origin_x      <= '0;
      cfg_q.origin_z      <= '0;
      cfg_q.inv_cell_size <= 32'd65536;
      cfg_q.height_scale  <= 24'd256;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* hdl/hmtq_mem.sv */
// ----------------------------------------------------------------------------
// hmtq_mem: height table storage
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module hmtq_mem #(
  parameter int AW = 16,
  parameter int DW = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/heightmap_triangle_height_query.sv */
// ----------------------------------------------------------------------------
// heightmap_triangle_height_query: grid height table with triangle lookup
// Loads grid-point heights and answers barycentric height queries.
// ----------------------------------------------------------------------------
// Usage: an input beat on in_data_i (valid/stall) is either a load, which
// writes one grid point into the height table, or a query, which returns one
// result beat on out_data_o (valid/stall). Loads return nothing.
// Registers are written over the cfg port (valid/ready, always ready) while
// the block is idle: a rule for the user that the block does not enforce.
// Sequence: a load writes the table and returns to idle. A query runs from
// accept to the result register through relative offset, four 17x32
// partial products for the two cell coordinates, cell locate, three table
// reads through the single read port with a multiply-accumulate, then
// rounding; a point off the grid skips the table reads. One item is in
// work at a time, so no new item is accepted until the last one is done.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and a query stalls in its last step only if the previous result
// is still held. Reset clears control and sets the registers to defaults;
// the table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module heightmap_triangle_height_query import hmtq_pkg::*; #(
  parameter int MAX_GRID = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int CW = (MAX_GRID > 2) ? $clog2(MAX_GRID) : 1;
  localparam int AW = $clog2(MAX_GRID * MAX_GRID);
  localparam int GW = ($clog2(MAX_GRID + 1) > 9) ? $clog2(MAX_GRID + 1) : 9;
  localparam logic [GW-1:0] GMax = GW'(MAX_GRID);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_LOAD = 13'b0000000000010,
    S_REL  = 13'b0000000000100,
    S_MX0  = 13'b0000000001000,
    S_MX1  = 13'b0000000010000,
    S_MZ0  = 13'b0000000100000,
    S_MZ1  = 13'b0000001000000,
    S_LOC  = 13'b0000010000000,
    S_RD0  = 13'b0000100000000,
    S_RD1  = 13'b0001000000000,
    S_RD2  = 13'b0010000000000,
    S_ACC  = 13'b0100000000000,
    S_RES  = 13'b1000000000000
  } state_e;

  cfg_t cfg;

  state_e state_q, state_d;
  in_item_t item_q;
  logic [32:0] mag_x_q, mag_z_q;
  logic        neg_x_q, neg_z_q;
  logic [64:0] prod_x_q, prod_x_d, prod_z_q, prod_z_d;
  logic [AW-1:0] addr_q [3];
  logic [16:0]   w_q [3];
  logic [41:0]   acc_q, acc_d;
  logic          inside_q;
  logic          out_valid_q;
  out_item_t     out_q;

  hmtq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  function automatic logic [AW-1:0] grid_addr(input logic [CW-1:0] col,
                                              input logic [CW-1:0] row);
    grid_addr = AW'(AW'(col) * AW'(MAX_GRID) + AW'(row));
  endfunction

  // Clamp the grid size in use and derive the last grid point index
  logic [GW-1:0] g, last;
  always_comb begin
    g = GW'(cfg.grid_points);
    if (g < GW'(2)) g = GW'(2);
    if (g > GMax)   g = GMax;
    last = g - GW'(1);
  end

  // Load path: color sum times scale, truncate, saturate, border test
  logic [9:0]    csum;
  logic [33:0]   lprod;
  logic [23:0]   lh;
  logic [GW-1:0] lcol, lrow;
  logic          border, in_table;
  always_comb begin
    csum   = 10'(item_q.red) + 10'(item_q.green) + 10'(item_q.blue);
    lprod  = 34'(csum) * 34'(cfg.height_scale);
    lh     = (lprod[33:8] > 26'hFFFFFF) ? 24'hFFFFFF : lprod[31:8];
    lcol   = GW'(item_q.grid_col);
    lrow   = GW'(item_q.grid_row);
    border = (lcol == '0) || (lcol >= last) || (lrow == '0) || (lrow >= last);
    in_table = (lcol < GMax) && (lrow < GMax);
  end

  // Shared partial product unit for the cell coordinates
  logic [16:0] pp_a;
  logic [48:0] pp;
  always_comb begin
    unique case (state_q)
      S_MX0:   pp_a = {1'b0, mag_x_q[15:0]};
      S_MX1:   pp_a = mag_x_q[32:16];
      S_MZ0:   pp_a = {1'b0, mag_z_q[15:0]};
      S_MZ1:   pp_a = mag_z_q[32:16];
      default: pp_a = '0;
    endcase
    pp = 49'(pp_a) * 49'(cfg.inv_cell_size);
  end

  always_comb begin
    prod_x_d = prod_x_q;
    prod_z_d = prod_z_q;
    if (state_q == S_MX0) prod_x_d = 65'(pp);
    if (state_q == S_MX1) prod_x_d = prod_x_q + (65'(pp) << 16);
    if (state_q == S_MZ0) prod_z_d = 65'(pp);
    if (state_q == S_MZ1) prod_z_d = prod_z_q + (65'(pp) << 16);
  end

  // Relative offsets from the origin
  logic signed [32:0] rel_x, rel_z;
  assign rel_x = 33'(item_q.query_x) - 33'(cfg.origin_x);
  assign rel_z = 33'(item_q.query_z) - 33'(cfg.origin_z);

  // Locate the cell and pick the triangle
  logic          in_x, in_z, upper;
  logic [CW-1:0] gx, gz, gx1, gz1;
  logic [15:0]   fx, fz;
  logic [17:0]   fsum;
  always_comb begin
    in_x = !(neg_x_q && (prod_x_q != '0)) && (prod_x_q[64:32] < 33'(last));
    in_z = !(neg_z_q && (prod_z_q != '0)) && (prod_z_q[64:32] < 33'(last));
    gx   = prod_x_q[32 +: CW];
    gz   = prod_z_q[32 +: CW];
    gx1  = gx + CW'(1);
    gz1  = gz + CW'(1);
    fx   = prod_x_q[31:16];
    fz   = prod_z_q[31:16];
    fsum = 18'(fx) + 18'(fz);
    upper = fsum > 18'd65536;
  end

  // Table access
  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [23:0]   mem_rdata;
  assign mem_we = (state_q == S_LOAD) && in_table;

  always_comb begin
    unique case (state_q)
      S_RD1:   mem_raddr = addr_q[1];
      S_RD2:   mem_raddr = addr_q[2];
      default: mem_raddr = addr_q[0];
    endcase
  end

  hmtq_mem #(.AW(AW), .DW(24)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (grid_addr(CW'(item_q.grid_col), CW'(item_q.grid_row))),
    .wdata_i (border ? 24'd0 : lh),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Weighted accumulate of the three corners
  logic [16:0] w_sel;
  logic [40:0] wprod;
  always_comb begin
    unique case (state_q)
      S_RD2:   w_sel = w_q[1];
      S_ACC:   w_sel = w_q[2];
      default: w_sel = w_q[0];
    endcase
    wprod = 41'(mem_rdata) * 41'(w_sel);
    acc_d = acc_q;
    if (state_q == S_RD1) acc_d = 42'(wprod);
    if (state_q == S_RD2 || state_q == S_ACC) acc_d = acc_q + 42'(wprod);
    if (state_q == S_LOC && !(in_x && in_z)) acc_d = '0;
  end

  // Round half up and saturate
  logic [41:0] rnd;
  logic [23:0] res_h;
  assign rnd   = acc_q + 42'd32768;
  assign res_h = (rnd[41:16] > 26'hFFFFFF) ? 24'hFFFFFF : rnd[39:16];

  logic res_take;
  assign res_take = (state_q == S_RES) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = (in_data_i.action == ACTION_LOAD) ? S_LOAD : S_REL;
      end
      S_LOAD: state_d = S_IDLE;
      S_REL:  state_d = S_MX0;
      S_MX0:  state_d = S_MX1;
      S_MX1:  state_d = S_MZ0;
      S_MZ0:  state_d = S_MZ1;
      S_MZ1:  state_d = S_LOC;
      S_LOC:  state_d = (in_x && in_z) ? S_RD0 : S_RES;
      S_RD0:  state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_ACC;
      S_ACC:  state_d = S_RES;
      S_RES: begin
        if (res_take) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) item_q <= in_data_i;
    if (state_q == S_REL) begin
      neg_x_q <= rel_x[32];
      neg_z_q <= rel_z[32];
      mag_x_q <= rel_x[32] ? 33'(-rel_x) : 33'(rel_x);
      mag_z_q <= rel_z[32] ? 33'(-rel_z) : 33'(rel_z);
    end
    prod_x_q <= prod_x_d;
    prod_z_q <= prod_z_d;
    acc_q    <= acc_d;
    if (state_q == S_LOC) begin
      inside_q <= in_x && in_z;
      if (upper) begin
        addr_q[0] <= grid_addr(gx1, gz);
        addr_q[1] <= grid_addr(gx1, gz1);
        addr_q[2] <= grid_addr(gx, gz1);
        w_q[0]    <= 17'(18'd65536 - 18'(fz));
        w_q[1]    <= 17'(fsum - 18'd65536);
        w_q[2]    <= 17'(18'd65536 - 18'(fx));
      end else begin
        addr_q[0] <= grid_addr(gx, gz);
        addr_q[1] <= grid_addr(gx1, gz);
        addr_q[2] <= grid_addr(gx, gz1);
        w_q[0]    <= 17'(18'd65536 - fsum);
        w_q[1]    <= 17'(fx);
        w_q[2]    <= 17'(fz);
      end
    end
    if (res_take) begin
      out_q.height     <= res_h;
      out_q.inside_res <= inside_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* test/tb_heightmap_triangle_height_query.sv */
// ----------------------------------------------------------------------------
// tb_heightmap_triangle_height_query: self-checking bench for the height query
// Loads grid points and issues height queries under a series of register
// settings, predicts each query result in order and checks every output beat
// against the oldest prediction, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_heightmap_triangle_height_query;
  import hmtq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxGrid  = 256;
  localparam int CycLimit = 1000000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  heightmap_triangle_height_query #(.MAX_GRID(MaxGrid)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Shadow registers and height table of the predictor
  logic [8:0]         sh_grid;
  logic signed [31:0] sh_org_x;
  logic signed [31:0] sh_org_z;
  logic [31:0]        sh_inv;
  logic [23:0]        sh_scale;
  logic [23:0]        height_tbl [MaxGrid*MaxGrid];
  bit                 loaded     [MaxGrid*MaxGrid];

  in_item_t  item_q[$];
  out_item_t height_q[$];

  int  err_cnt, cyc, n_load, n_inside, n_outside, n_beats;
  bit  in_acc, out_acc, burst;
  int  in_gap, out_wait;

  function automatic int unsigned grid_used();
    int unsigned g;
    g = sh_grid;
    if (g < 2) g = 2;
    if (g > MaxGrid) g = MaxGrid;
    return g;
  endfunction

  // Map one axis to cell and Q0.16 fraction; 0 when off the grid
  function automatic bit find_cell(logic signed [31:0] q, logic signed [31:0] org,
                                   int unsigned last, output int unsigned cidx,
                                   output int unsigned frac);
    longint            rel;
    longint unsigned   mag;
    longint unsigned   prod;
    rel  = longint'(q) - longint'(org);
    mag  = (rel < 0) ? -rel : rel;
    prod = mag * {32'd0, sh_inv};
    cidx = 0;
    frac = 0;
    if (rel < 0 && prod != 0) return 1'b0;
    if ((prod >> 32) >= last) return 1'b0;
    cidx = int'(prod >> 32);
    frac = int'((prod >> 16) & 64'hFFFF);
    return 1'b1;
  endfunction

  function automatic int tidx(int unsigned c, int unsigned r);
    return c * MaxGrid + r;
  endfunction

  // True unless the query would read a table entry never loaded
  function automatic bit reads_loaded(in_item_t it);
    int unsigned gx, gz, fx, fz, g;
    g = grid_used();
    if (!find_cell(it.query_x, sh_org_x, g - 1, gx, fx) ||
        !find_cell(it.query_z, sh_org_z, g - 1, gz, fz)) return 1'b1;
    if (fx + fz <= 65536)
      return loaded[tidx(gx, gz)] && loaded[tidx(gx+1, gz)] && loaded[tidx(gx, gz+1)];
    return loaded[tidx(gx+1, gz)] && loaded[tidx(gx+1, gz+1)] && loaded[tidx(gx, gz+1)];
  endfunction

  // Advance the predictor by one beat and queue it, with its expected result for a query
  function automatic void push_item(in_item_t it);
    int unsigned     g, c, r, gx, gz, fx, fz;
    longint unsigned h, acc;
    out_item_t       res;
    g = grid_used();
    if (it.action == ACTION_LOAD) begin
      c = it.grid_col;
      r = it.grid_row;
      if (c == 0 || c >= g - 1 || r == 0 || r >= g - 1) begin
        h = 0;
      end else begin
        h = ((longint'(it.red) + it.green + it.blue) * {40'd0, sh_scale}) >> 8;
        if (h > 64'hFFFFFF) h = 64'hFFFFFF;
      end
      height_tbl[tidx(c, r)] = h[23:0];
      loaded[tidx(c, r)] = 1'b1;
      n_load++;
    end else begin
      if (!find_cell(it.query_x, sh_org_x, g - 1, gx, fx) ||
          !find_cell(it.query_z, sh_org_z, g - 1, gz, fz)) begin
        res = '0;
        n_outside++;
      end else begin
        if (fx + fz <= 65536)
          acc = height_tbl[tidx(gx, gz)] * longint'(65536 - fx - fz)
              + height_tbl[tidx(gx+1, gz)] * longint'(fx)
              + height_tbl[tidx(gx, gz+1)] * longint'(fz);
        else
          acc = height_tbl[tidx(gx+1, gz)] * longint'(65536 - fz)
              + height_tbl[tidx(gx+1, gz+1)] * longint'(fx + fz - 65536)
              + height_tbl[tidx(gx, gz+1)] * longint'(65536 - fx);
        acc = (acc + 32768) >> 16;
        if (acc > 64'hFFFFFF) acc = 64'hFFFFFF;
        res.height = acc[23:0];
        res.inside_res = 1'b1;
        n_inside++;
      end
      height_q.push_back(res);
    end
    item_q.push_back(it);
  endfunction

  function automatic in_item_t mk_load(int c, int r, int rd, int gr, int bl);
    in_item_t it;
    it = in_item_t'(105'({$urandom, $urandom, $urandom, $urandom}));
    it.action   = ACTION_LOAD;
    it.grid_col = 8'(c);
    it.grid_row = 8'(r);
    it.red      = 8'(rd);
    it.green    = 8'(gr);
    it.blue     = 8'(bl);
    return it;
  endfunction

  function automatic in_item_t mk_query(logic [31:0] x, logic [31:0] z);
    in_item_t it;
    it = in_item_t'(105'({$urandom, $urandom, $urandom, $urandom}));
    it.action  = ACTION_QUERY;
    it.query_x = x;
    it.query_z = z;
    return it;
  endfunction

  // Queue a query only if it stays within loaded entries
  function automatic void push_query(in_item_t it);
    if (reads_loaded(it)) push_item(it);
  endfunction

  // World coordinate that lands in a given cell, or 0 when it does not fit
  function automatic bit aim_axis(int unsigned cidx, logic signed [31:0] org,
                                  output logic [31:0] q);
    longint unsigned num;
    longint          w;
    num = ({32'd0, cidx} << 32) | {32'd0, $urandom};
    if (sh_inv == 0) w = longint'(org) + $urandom_range(0, 65535);
    else             w = longint'(org) + longint'(num / sh_inv);
    q = w[31:0];
    return w <= 64'sh7FFFFFFF;
  endfunction

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] d);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    case (idx)
      CFG_GRID_POINTS:   sh_grid  = d[8:0];
      CFG_ORIGIN_X:      sh_org_x = d;
      CFG_ORIGIN_Z:      sh_org_z = d;
      CFG_INV_CELL_SIZE: sh_inv   = d;
      CFG_HEIGHT_SCALE:  sh_scale = d[23:0];
      default: ;
    endcase
  endtask

  // Hold until every beat is sent and every result is back, then let it settle
  task automatic wait_drain();
    while (item_q.size() != 0 || height_q.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // One register setting: load the region, then mix loads and queries
  task automatic run_phase(logic [8:0] gp, logic [31:0] ox, logic [31:0] oz,
                           logic [31:0] inv, logic [23:0] sc, int n);
    int unsigned g, clo, chi, rlo, rhi, gx, gz, k, j, tmp;
    int unsigned order[$];
    logic [31:0] qx, qz;
    wait_drain();
    cfg_write(CFG_GRID_POINTS, {23'd0, gp});
    cfg_write(CFG_ORIGIN_X, ox);
    cfg_write(CFG_ORIGIN_Z, oz);
    cfg_write(CFG_INV_CELL_SIZE, inv);
    cfg_write(CFG_HEIGHT_SCALE, {8'd0, sc});
    g = grid_used();
    if (g <= 16) begin
      clo = 0; chi = g - 1; rlo = 0; rhi = g - 1;
    end else begin
      clo = $urandom_range(0, g - 13); chi = clo + 11;
      rlo = $urandom_range(0, g - 13); rhi = rlo + 11;
    end
    // load the region in shuffled order
    order.delete();
    for (int c = clo; c <= chi; c++)
      for (int r = rlo; r <= rhi; r++) order.push_back(c * MaxGrid + r);
    for (k = order.size(); k > 1; k--) begin
      j = $urandom_range(0, k - 1);
      tmp = order[k-1]; order[k-1] = order[j]; order[j] = tmp;
    end
    foreach (order[i])
      push_item(mk_load(order[i] / MaxGrid, order[i] % MaxGrid,
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255)));
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 22) begin
        push_item(mk_load($urandom_range(clo, chi), $urandom_range(rlo, rhi),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255)));
      end else if (k < 25) begin
        push_item(mk_load($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255)));
      end else if (k < 85) begin
        gx = $urandom_range(clo, chi - 1);
        gz = $urandom_range(rlo, rhi - 1);
        if (aim_axis(gx, sh_org_x, qx) && aim_axis(gz, sh_org_z, qz))
          push_query(mk_query(qx, qz));
      end else begin
        push_query(mk_query($urandom, $urandom));
      end
      if (item_q.size() > 64) begin
        while (item_q.size() > 16) @(posedge clk_i);
      end
    end
  endtask

  // Input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_acc)) begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (item_q.size() != 0) begin
        in_data_i  <= item_q.pop_front();
        in_valid_i <= 1'b1;
        in_gap = burst ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_acc) out_wait = burst ? 0 : $urandom_range(0, 5);
      if (out_wait > 0) begin
        out_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor and checker
  always @(posedge clk_i) begin
    out_item_t want;
    in_acc  <= rst_ni && in_valid_i && !in_stall_o;
    out_acc <= rst_ni && out_valid_o && !out_stall_i;
    cyc++;
    if (cyc > CycLimit) begin
      $display("%0t: timeout, %0d results still pending", $time, height_q.size());
      $display("tb_heightmap_triangle_height_query: done, errors");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      n_beats++;
      if (height_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat, expected none, actual %h/%b", $time,
                 out_data_o.height, out_data_o.inside_res);
      end else begin
        want = height_q.pop_front();
        if (out_data_o.height !== want.height) begin
          err_cnt++;
          $display("%0t: height mismatch, expected %h, actual %h", $time,
                   want.height, out_data_o.height);
        end
        if (out_data_o.inside_res !== want.inside_res) begin
          err_cnt++;
          $display("%0t: inside_res mismatch, expected %b, actual %b", $time,
                   want.inside_res, out_data_o.inside_res);
        end
      end
    end
  end

  // Stimulus
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_GRID_POINTS;
    cfg_data_i  = '0;
    sh_grid  = 9'd256;
    sh_org_x = '0;
    sh_org_z = '0;
    sh_inv   = 32'd65536;
    sh_scale = 24'd256;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset setting, extremes, borders, both triangles, off-grid points
    push_item(mk_load(1, 1, 255, 255, 255));
    push_item(mk_load(2, 1, 0, 0, 0));
    push_item(mk_load(1, 2, 10, 20, 30));
    push_item(mk_load(2, 2, 128, 64, 1));
    push_item(mk_load(0, 0, 255, 255, 255));
    push_item(mk_load(1, 0, 7, 7, 7));
    push_item(mk_load(0, 1, 9, 9, 9));
    push_item(mk_load(255, 7, 1, 2, 3));
    push_item(mk_load(5, 255, 1, 2, 3));
    push_query(mk_query(32'h0001_0000, 32'h0001_0000));
    push_query(mk_query(32'h0001_FFFF, 32'h0001_0000));
    push_query(mk_query(32'h0001_8000, 32'h0001_8000));
    push_query(mk_query(32'h0001_4000, 32'h0001_C000));
    push_query(mk_query(32'h0001_FFFF, 32'h0001_FFFF));
    push_query(mk_query(32'h0000_8000, 32'h0000_4000));
    push_query(mk_query(32'hFFFF_FFFF, 32'h0001_0000));
    push_query(mk_query(32'h8000_0000, 32'h0001_0000));
    push_query(mk_query(32'h7FFF_FFFF, 32'h0001_0000));
    push_query(mk_query(32'h00FF_0000, 32'h0001_0000));
    push_query(mk_query(32'h0001_0000, 32'h00FF_0000));
    push_query(mk_query(32'h0001_0000, 32'h8000_0000));

    // settings, extremes first
    run_phase(9'd2,   32'd0,          32'd0,          32'd65536,      24'd256,    40);
    run_phase(9'd0,   32'h0000_1234,  32'hFFFF_0000,  32'd0,          24'hFFFFFF, 40);
    run_phase(9'd1,   32'd0,          32'd0,          32'd65536,      24'd0,      30);
    run_phase(9'd5,   32'hFFF0_0000,  32'h0010_0000,  32'd32768,      24'($urandom), 50);
    run_phase(9'd8,   32'd0,          32'd0,          32'hFFFF_FFFF,  24'hFFFFFF, 50);
    run_phase(9'd16,  32'h8000_0000,  32'h7FFF_FFFF,  32'd65536,      24'd256,    40);
    run_phase(9'd511, 32'd0,          32'd0,          32'd65536,      24'($urandom), 50);
    run_phase(9'd256, $urandom_range(0, 32'h00FF_FFFF), 32'hFF00_0000,
              $urandom_range(20000, 300000), 24'($urandom), 50);
    run_phase(9'd300, 32'h0000_8000,  32'd0,          32'd131072,     24'd1000,   50);
    for (int p = 0; p < 2; p++)
      run_phase(9'($urandom_range(3, 12)),
                $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000,
                $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000,
                ($urandom_range(0, 1) != 0) ? 32'd65536 : $urandom_range(20000, 300000),
                24'($urandom), 55);

    wait_drain();
    $display("Covered %0d loads and %0d queries (%0d inside, %0d off grid)",
             n_load, n_inside + n_outside, n_inside, n_outside);
    $display("%0d result beats checked over 12 register settings", n_beats);
    if (err_cnt == 0) begin
      $display("tb_heightmap_triangle_height_query: done, clean");
    end else begin
      $display("tb_heightmap_triangle_height_query: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/hmtq_pkg.sv
hdl/hmtq_cfg.sv
hdl/hmtq_mem.sv
hdl/heightmap_triangle_height_query.sv
test/tb_heightmap_triangle_height_query.sv
